// ===== sv/bar_meter_peak_hold_core_macros.svh =====
// Assertion macros shared by the bar meter RTL.
`ifndef BAR_METER_PEAK_HOLD_CORE_MACROS_SVH
`define BAR_METER_PEAK_HOLD_CORE_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, sampled on aclk, off during reset.
`define BMPH_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("bar meter assertion failed");
// Next-cycle implication, sampled on aclk, off during reset.
`define BMPH_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("bar meter assertion failed");
`else
`define BMPH_ASSERT_IMP(lbl, ante, cons)
`define BMPH_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== sv/bmph_pkg.sv =====
// Shared constants for the bar meter with peak hold.
`default_nettype none
package bmph_pkg;

    localparam int CH_W    = 5;
    localparam int FREQ_W  = 18;
    localparam int REG_W   = 17;
    localparam int BAR_W   = 6;
    localparam int SEG_W   = 4;
    localparam int FILL_W  = 2;

    localparam int BAR_STEPS     = 48;
    localparam int STEPS_PER_SEG = 4;
    localparam int SEG_SHIFT     = $clog2(STEPS_PER_SEG);

    // quotient never exceeds BAR_STEPS, so BAR_W quotient bits suffice
    localparam int Q_W   = BAR_W;
    localparam int NUM_W = REG_W + Q_W;

    localparam logic [REG_W-1:0] LOW_RESET  = REG_W'(11000);
    localparam logic [REG_W-1:0] HIGH_RESET = REG_W'(99000);

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH = 1'b1;

    localparam int NUM_CHANNELS_DEF = 32;

endpackage
`default_nettype wire

// ===== sv/bmph_ram.sv =====
// Generic single-port-write, registered-read RAM.
`default_nettype none
module bmph_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== sv/bmph_div.sv =====
// Iterative restoring divider: one quotient bit per cycle.
`default_nettype none
module bmph_div (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [bmph_pkg::NUM_W-1:0]  dividend,
    input  wire logic [bmph_pkg::REG_W-1:0]  divisor,
    output logic                             busy,
    output logic      [bmph_pkg::Q_W-1:0]    quotient
);
    import bmph_pkg::*;

    localparam int CNT_W = $clog2(Q_W + 1);

    logic [NUM_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] dvs_reg, dvs_next;
    logic [Q_W-1:0]   q_reg, q_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             ge;

    assign ge = rem_reg >= dvs_reg;

    always_comb begin
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            rem_next  = dividend;
            // align divisor with the top quotient bit
            dvs_next  = NUM_W'(divisor) << (Q_W - 1);
            q_next    = '0;
            cnt_next  = CNT_W'(Q_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = ge ? (rem_reg - dvs_reg) : rem_reg;
            q_next   = {q_reg[Q_W-2:0], ge};
            dvs_next = dvs_reg >> 1;
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        q_reg   <= q_next;
    end

    assign busy     = busy_reg;
    assign quotient = q_reg;

endmodule
`default_nettype wire

// ===== sv/bar_meter_peak_hold_core.sv =====
// Bar meter with falling peak marker: a column per channel.
//
// Input channel (s_*): valid/ready requests. mode 0 updates one channel's
// column from its frequency; mode 1 clears every peak marker and returns
// nothing. A channel at or above NUM_CHANNELS is dropped.
// Result channel (m_*): valid/ready, one result per in-range update.
// Configuration: cfg_we writes range_low (index 0) or range_high (index 1)
// from cfg_data; write only while the block is idle.
// An update occupies the block through latch, clamp, divider load,
// six passes through the shared compare/subtract divider, and the peak
// update. The result becomes valid in the same cycle that the next
// request can be taken. The output register decouples the sides, so a
// stalled receiver holds one result while the next update runs; a second
// result waits in the divider until the register frees up.
// Reset restores the range defaults and reads all peaks and last levels
// as zero (per-channel valid bits; no clearing pass).
`default_nettype none
`include "bar_meter_peak_hold_core_macros.svh"
module bar_meter_peak_hold_core #(
    parameter int NUM_CHANNELS = bmph_pkg::NUM_CHANNELS_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_we,
    input  wire logic [bmph_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [bmph_pkg::REG_W-1:0]       cfg_data,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic                             s_mode,
    input  wire logic [bmph_pkg::CH_W-1:0]        s_channel,
    input  wire logic                             s_voice_active,
    input  wire logic                             s_channel_enabled,
    input  wire logic [bmph_pkg::FREQ_W-1:0]      s_frequency,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic      [bmph_pkg::CH_W-1:0]        m_out_channel,
    output logic      [bmph_pkg::BAR_W-1:0]       m_bar_level,
    output logic      [bmph_pkg::SEG_W-1:0]       m_full_segments,
    output logic      [bmph_pkg::FILL_W-1:0]      m_partial_fill,
    output logic      [bmph_pkg::BAR_W-1:0]       m_peak_level
);
    import bmph_pkg::*;

    localparam int AW    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int RAM_W = 2 * BAR_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CLAMP = 2'd1;
    localparam logic [1:0] ST_LOAD  = 2'd2;
    localparam logic [1:0] ST_DIV   = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [REG_W-1:0]  low_reg, high_reg;
    logic [CH_W-1:0]   ch_reg;
    logic [FREQ_W-1:0] lvl_reg;
    logic [REG_W-1:0]  diff_reg, den_reg;
    logic [NUM_CHANNELS-1:0] peak_vld_reg, last_vld_reg;

    logic [CH_W-1:0]   out_ch_reg;
    logic [BAR_W-1:0]  out_bar_reg, out_peak_reg;
    logic              m_valid_reg, m_valid_next;

    logic              accept, in_range, finish;
    logic [AW-1:0]     addr;
    logic [FREQ_W-1:0] lo_ext, hi_ext, clamped;
    logic              empty_range;
    logic [REG_W-1:0]  diff_c, den_c;

    logic              div_start, div_busy;
    logic [Q_W-1:0]    quotient;
    logic [RAM_W-1:0]  rd_data;
    logic [BAR_W-1:0]  peak_old, last_old, peak_dec, peak_new, bar;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign in_range = 32'(s_channel) < NUM_CHANNELS;
    assign addr     = AW'(ch_reg);

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_reg  <= LOW_RESET;
            high_reg <= HIGH_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_RANGE_LOW:  low_reg  <= cfg_data;
                CFG_RANGE_HIGH: high_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // clamp into the configured range and take the offset
    assign lo_ext      = FREQ_W'(low_reg);
    assign hi_ext      = FREQ_W'(high_reg);
    assign empty_range = high_reg <= low_reg;

    always_comb begin
        if (lvl_reg < lo_ext) begin
            clamped = lo_ext;
        end else if (lvl_reg > hi_ext) begin
            clamped = hi_ext;
        end else begin
            clamped = lvl_reg;
        end
        diff_c = empty_range ? '0 : REG_W'(clamped - lo_ext);
        den_c  = empty_range ? REG_W'(1) : (high_reg - low_reg);
    end

    assign div_start = (state_reg == ST_LOAD);

    bmph_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (NUM_W'(diff_reg) * NUM_W'(BAR_STEPS)),
        .divisor  (den_reg),
        .busy     (div_busy),
        .quotient (quotient)
    );

    // peak marker and last level share one entry per channel
    assign bar      = quotient;
    assign peak_old = peak_vld_reg[addr] ? rd_data[RAM_W-1:BAR_W] : '0;
    assign last_old = last_vld_reg[addr] ? rd_data[BAR_W-1:0] : '0;
    assign peak_dec = (peak_old > last_old) ? (peak_old - BAR_W'(1)) : peak_old;
    assign peak_new = (peak_dec <= bar) ? bar : (peak_dec - BAR_W'(1));

    assign finish = (state_reg == ST_DIV) && !div_busy && (!m_valid_reg || m_ready);

    bmph_ram #(
        .WIDTH (RAM_W),
        .DEPTH (NUM_CHANNELS),
        .AW    (AW)
    ) u_store (
        .aclk  (aclk),
        .we    (finish),
        .waddr (addr),
        .wdata ({peak_new, bar}),
        .raddr (addr),
        .rdata (rd_data)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && !s_mode && in_range) begin
                    state_next = ST_CLAMP;
                end
            end
            ST_CLAMP: state_next = ST_LOAD;
            ST_LOAD:  state_next = ST_DIV;
            ST_DIV: begin
                if (finish) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        if (finish) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_valid_reg  <= 1'b0;
            peak_vld_reg <= '0;
            last_vld_reg <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (accept && s_mode) begin
                peak_vld_reg <= '0;
            end else if (finish) begin
                peak_vld_reg[addr] <= 1'b1;
                last_vld_reg[addr] <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            ch_reg  <= s_channel;
            lvl_reg <= (s_voice_active && s_channel_enabled) ? s_frequency : '0;
        end
        if (state_reg == ST_CLAMP) begin
            diff_reg <= diff_c;
            den_reg  <= den_c;
        end
        if (finish) begin
            out_ch_reg   <= ch_reg;
            out_bar_reg  <= bar;
            out_peak_reg <= peak_new;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_out_channel   = out_ch_reg;
    assign m_bar_level     = out_bar_reg;
    assign m_full_segments = SEG_W'(out_bar_reg >> SEG_SHIFT);
    assign m_partial_fill  = out_bar_reg[FILL_W-1:0];
    assign m_peak_level    = out_peak_reg;

    `BMPH_ASSERT_IMP(a_bar_in_scale, m_valid, (m_bar_level <= BAR_W'(BAR_STEPS)) && (m_peak_level <= BAR_W'(BAR_STEPS)))
    `BMPH_ASSERT_IMP(a_peak_not_below_bar, m_valid, m_peak_level >= m_bar_level)
    `BMPH_ASSERT_IMP(a_div_only_in_div, div_busy, state_reg == ST_DIV)
    `BMPH_ASSERT_NEXT(a_clear_peaks, s_valid && s_ready && s_mode, peak_vld_reg == '0)

endmodule
`default_nettype wire

// ===== dv/bar_meter_peak_hold_core_tb.sv =====
// Self-checking testbench for the bar meter with peak hold: directed table, then random phases.
`default_nettype none
module bar_meter_peak_hold_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bmph_pkg::*;

    localparam logic MODE_UPDATE = 1'b0;
    localparam logic MODE_CLEAR  = 1'b1;
    localparam int   CHANNELS    = 32;
    localparam int   DRAIN_WAIT  = 12;
    localparam int   STALL_LIMIT = 2000;
    localparam int   NUM_PHASES  = 7;
    localparam int   PHASE_REQS  = 80;
    localparam int   DIR_N       = 17;

    typedef struct packed {
        logic              mode;
        logic [CH_W-1:0]   channel;
        logic              active;
        logic              enabled;
        logic [FREQ_W-1:0] freq;
    } meter_req_t;

    typedef struct packed {
        logic [CH_W-1:0]   channel;
        logic [BAR_W-1:0]  bar;
        logic [SEG_W-1:0]  segs;
        logic [FILL_W-1:0] fill;
        logic [BAR_W-1:0]  peak;
    } meter_res_t;

    typedef struct packed {
        meter_req_t req;
        logic       typed;
        meter_res_t res;
    } dir_row_t;

    // typed rows carry their result; the rest go through the predictor
    localparam dir_row_t DIR_TBL [DIR_N] = '{
        '{'{MODE_UPDATE, 5'd0, 1'b1, 1'b1, 18'd0}, 1'b1,
          '{5'd0, 6'd0, 4'd0, 2'd0, 6'd0}},
        '{'{MODE_UPDATE, 5'd31, 1'b1, 1'b1, 18'd262143}, 1'b1,
          '{5'd31, 6'd48, 4'd12, 2'd0, 6'd48}},
        '{'{MODE_UPDATE, 5'd31, 1'b0, 1'b1, 18'd262143}, 1'b1,
          '{5'd31, 6'd0, 4'd0, 2'd0, 6'd47}},
        '{'{MODE_UPDATE, 5'd31, 1'b1, 1'b0, 18'd262143}, 1'b1,
          '{5'd31, 6'd0, 4'd0, 2'd0, 6'd45}},
        '{'{MODE_UPDATE, 5'd31, 1'b1, 1'b1, 18'd99000}, 1'b1,
          '{5'd31, 6'd48, 4'd12, 2'd0, 6'd48}},
        '{'{MODE_UPDATE, 5'd31, 1'b1, 1'b1, 18'd11000}, 1'b0, '0},
        '{'{MODE_UPDATE, 5'd31, 1'b1, 1'b1, 18'd10999}, 1'b0, '0},
        '{'{MODE_UPDATE, 5'd5, 1'b1, 1'b1, 18'd55000}, 1'b1,
          '{5'd5, 6'd24, 4'd6, 2'd0, 6'd24}},
        '{'{MODE_UPDATE, 5'd5, 1'b1, 1'b1, 18'd12834}, 1'b0, '0},
        '{'{MODE_UPDATE, 5'd5, 1'b1, 1'b1, 18'd16500}, 1'b0, '0},
        '{'{MODE_CLEAR, 5'd0, 1'b0, 1'b0, 18'd0}, 1'b0, '0},
        '{'{MODE_UPDATE, 5'd31, 1'b1, 1'b1, 18'd0}, 1'b1,
          '{5'd31, 6'd0, 4'd0, 2'd0, 6'd0}},
        '{'{MODE_UPDATE, 5'd5, 1'b1, 1'b1, 18'd98999}, 1'b0, '0},
        '{'{MODE_CLEAR, 5'd31, 1'b1, 1'b1, 18'd262143}, 1'b0, '0},
        '{'{MODE_UPDATE, 5'd5, 1'b0, 1'b0, 18'd0}, 1'b0, '0},
        '{'{MODE_UPDATE, 5'd10, 1'b1, 1'b1, 18'd131071}, 1'b0, '0},
        '{'{MODE_UPDATE, 5'd10, 1'b1, 1'b1, 18'd131072}, 1'b0, '0}
    };

    // range, idling and stalling per random phase; extremes, empty and inverted ranges included
    localparam int PH_LO    [NUM_PHASES] = '{0, 11000, 131070, 0, 500, 131071, 1000};
    localparam int PH_HI    [NUM_PHASES] = '{131071, 99000, 131071, 1, 500, 0, 1048};
    localparam int PH_IDLE  [NUM_PHASES] = '{0, 45, 0, 34, 34, 0, 34};
    localparam int PH_STALL [NUM_PHASES] = '{0, 0, 45, 34, 34, 0, 34};

    logic                 aclk              = 1'b0;
    logic                 aresetn           = 1'b0;
    logic                 cfg_we            = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index         = CFG_RANGE_LOW;
    logic [REG_W-1:0]     cfg_data          = '0;
    logic                 s_valid           = 1'b0;
    logic                 s_ready;
    logic                 s_mode            = MODE_UPDATE;
    logic [CH_W-1:0]      s_channel         = '0;
    logic                 s_voice_active    = 1'b0;
    logic                 s_channel_enabled = 1'b0;
    logic [FREQ_W-1:0]    s_frequency       = '0;
    logic                 m_valid;
    logic                 m_ready           = 1'b0;
    logic [CH_W-1:0]      m_out_channel;
    logic [BAR_W-1:0]     m_bar_level;
    logic [SEG_W-1:0]     m_full_segments;
    logic [FILL_W-1:0]    m_partial_fill;
    logic [BAR_W-1:0]     m_peak_level;

    bar_meter_peak_hold_core dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_mode            (s_mode),
        .s_channel         (s_channel),
        .s_voice_active    (s_voice_active),
        .s_channel_enabled (s_channel_enabled),
        .s_frequency       (s_frequency),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_out_channel     (m_out_channel),
        .m_bar_level       (m_bar_level),
        .m_full_segments   (m_full_segments),
        .m_partial_fill    (m_partial_fill),
        .m_peak_level      (m_peak_level)
    );

    always #5 aclk = ~aclk;

    // predictor state
    logic [REG_W-1:0] range_lo = LOW_RESET;
    logic [REG_W-1:0] range_hi = HIGH_RESET;
    logic [BAR_W-1:0] peak_mem [CHANNELS];
    logic [BAR_W-1:0] last_bar_mem [CHANNELS];

    meter_res_t  pending_bars [$];
    meter_res_t  head_bar;
    int          fail_cnt  = 0;
    int          idle_pct  = 0;
    int          stall_pct = 0;
    int          quiet_cycles = 0;
    logic [CH_W-1:0] focus_ch = '0;

    initial begin
        for (int i = 0; i < CHANNELS; i++) begin
            peak_mem[i]     = '0;
            last_bar_mem[i] = '0;
        end
    end

    function automatic logic [BAR_W-1:0] scale_bar(input int unsigned level);
        int unsigned lo;
        int unsigned hi;
        lo = 32'(range_lo);
        hi = 32'(range_hi);
        if (hi <= lo)
            return '0;
        if (level < lo)
            level = lo;
        else if (level > hi)
            level = hi;
        return BAR_W'(((level - lo) * BAR_STEPS) / (hi - lo));
    endfunction

    // advance the column and peak state; returns 1 when the request yields a result
    function automatic bit update_column(input meter_req_t r, output meter_res_t res);
        logic [BAR_W-1:0] bar;
        logic [BAR_W-1:0] pk;
        res = '0;
        if (r.mode == MODE_CLEAR) begin
            for (int i = 0; i < CHANNELS; i++)
                peak_mem[i] = '0;
            return 1'b0;
        end
        bar = scale_bar((r.active && r.enabled) ? int'(r.freq) : 0);
        pk  = peak_mem[r.channel];
        if (pk > last_bar_mem[r.channel])
            pk = pk - BAR_W'(1);
        last_bar_mem[r.channel] = bar;
        if (pk <= bar)
            pk = bar;
        else
            pk = pk - BAR_W'(1);
        peak_mem[r.channel] = pk;
        res.channel = r.channel;
        res.bar     = bar;
        res.segs    = SEG_W'(bar / STEPS_PER_SEG);
        res.fill    = FILL_W'(bar % STEPS_PER_SEG);
        res.peak    = pk;
        return 1'b1;
    endfunction

    function automatic logic [FREQ_W-1:0] near_freq(input int center);
        int v;
        v = center + int'($urandom_range(2)) - 1;
        if (v < 0)
            v = 0;
        return FREQ_W'(v);
    endfunction

    function automatic meter_req_t rand_req();
        meter_req_t r;
        r.mode    = ($urandom_range(99) < 5) ? MODE_CLEAR : MODE_UPDATE;
        // stay on one column for a while so the peak marker rises and decays
        if ($urandom_range(99) < 10)
            focus_ch = CH_W'($urandom_range(CHANNELS - 1));
        r.channel = ($urandom_range(99) < 60) ? focus_ch : CH_W'($urandom_range(CHANNELS - 1));
        r.active  = ($urandom_range(99) < 88);
        r.enabled = ($urandom_range(99) < 88);
        case ($urandom_range(9))
            0: r.freq = FREQ_W'($urandom);
            1: r.freq = '0;
            2: r.freq = '1;
            3: r.freq = near_freq(int'(range_lo));
            4: r.freq = near_freq(int'(range_hi));
            default: begin
                if (range_hi > range_lo)
                    r.freq = FREQ_W'(range_lo + $urandom_range(int'(range_hi - range_lo)));
                else
                    r.freq = FREQ_W'($urandom);
            end
        endcase
        return r;
    endfunction

    task automatic send_req(input meter_req_t r, input logic typed, input meter_res_t typed_res,
                            input bit drain_first);
        int         gap;
        meter_res_t res;
        gap = 0;
        while ($urandom_range(99) < idle_pct)
            gap++;
        if (drain_first && gap == 0)
            gap = 1;
        if (gap != 0) begin
            s_valid <= 1'b0;
            if (drain_first)
                while (pending_bars.size() != 0)
                    @(posedge aclk);
            repeat (gap) @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_mode            <= r.mode;
        s_channel         <= r.channel;
        s_voice_active    <= r.active;
        s_channel_enabled <= r.enabled;
        s_frequency       <= r.freq;
        do
            @(posedge aclk);
        while (!s_ready);
        if (update_column(r, res))
            pending_bars.push_back(typed ? typed_res : res);
    endtask

    // drain, let a clear request settle, then write both range registers
    task automatic set_range(input int lo, input int hi);
        s_valid <= 1'b0;
        while (pending_bars.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_RANGE_LOW;
        cfg_data  <= REG_W'(lo);
        @(posedge aclk);
        cfg_index <= CFG_RANGE_HIGH;
        cfg_data  <= REG_W'(hi);
        @(posedge aclk);
        cfg_we   <= 1'b0;
        range_lo = REG_W'(lo);
        range_hi = REG_W'(hi);
    endtask

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_cnt++;
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_bars.size() == 0) begin
                $error("unexpected result on channel %0d", m_out_channel);
                fail_cnt++;
            end else begin
                head_bar = pending_bars.pop_front();
                check_field("out_channel", int'(head_bar.channel), int'(m_out_channel));
                check_field("bar_level", int'(head_bar.bar), int'(m_bar_level));
                check_field("full_segments", int'(head_bar.segs), int'(m_full_segments));
                check_field("partial_fill", int'(head_bar.fill), int'(m_partial_fill));
                check_field("peak_level", int'(head_bar.peak), int'(m_peak_level));
            end
        end
    end

    // end the run when nothing moves on either channel for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIR_N; i++)
            send_req(DIR_TBL[i].req, DIR_TBL[i].typed, DIR_TBL[i].res, 1'b0);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            set_range(PH_LO[ph], PH_HI[ph]);
            idle_pct  = PH_IDLE[ph];
            stall_pct = PH_STALL[ph];
            for (int n = 0; n < PHASE_REQS; n++)
                send_req(rand_req(), 1'b0, '0, ($urandom_range(99) < 2));
        end

        s_valid <= 1'b0;
        while (pending_bars.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT * 2) @(posedge aclk);
        if (fail_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
`default_nettype wire
